### src/rite_pkg.sv
package rite_pkg;

    localparam logic [1:0] CLS_OTHER  = 2'd0;
    localparam logic [1:0] CLS_ALPHA  = 2'd1;
    localparam logic [1:0] CLS_ZERO   = 2'd2;
    localparam logic [1:0] CLS_NUMBER = 2'd3;

    localparam logic [3:0] TY_STRING = 4'd2;
    localparam logic [3:0] TY_CHAR   = 4'd3;
    localparam logic [3:0] TY_DIGITS = 4'd4;
    localparam logic [3:0] TY_DDELTA = 4'd5;
    localparam logic [3:0] TY_MATCH  = 4'd8;
    localparam logic [3:0] TY_END    = 4'd9;

    localparam logic [2:0] ST_TYPE   = 3'd0;
    localparam logic [2:0] ST_STR    = 3'd2;
    localparam logic [2:0] ST_CHAR   = 3'd3;
    localparam logic [2:0] ST_DIGITS = 3'd4;
    localparam logic [2:0] ST_DELTA  = 3'd5;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_TOKENS = 2'd1;
    localparam logic [1:0] ERR_LONG   = 2'd2;

    localparam logic [31:0] NUM_LIMIT = 32'd536870912;
    localparam logic [7:0]  CH_ZERO   = 8'd48;

    typedef struct packed {
        logic [7:0] id_char;
        logic       last_of_id;
        logic       empty_id;
        logic       update_only;
    } t_in_req;

    typedef struct packed {
        logic [6:0]  token_index;
        logic [2:0]  stream_index;
        logic [31:0] value;
        logic        last_result;
        logic [1:0]  error_code;
    } t_out_req;

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'd65) && (c <= 8'd90)) || ((c >= 8'd97) && (c <= 8'd122));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'd48) && (c <= 8'd57);
    endfunction

endpackage

### src/rite_if.sv
interface rite_req_if;
    import rite_pkg::*;
    logic    valid;
    logic    ready;
    t_in_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rite_res_if;
    import rite_pkg::*;
    logic     valid;
    logic     ready;
    t_out_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### src/rite_ram.sv
module rite_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### src/read_id_token_encoder_core.sv
// Channel   Dir  Payload                                              Handshake
// i_req     in   id_char, last_of_id, empty_id, update_only          valid/ready
// o_res     out  token_index, stream_index, value, last_result,      valid/ready
//                error_code
// A character that extends a token passes through S_IDLE, S_DEC, S_ADD, S_ENDCHK and
// S_FIN; opening a token adds S_OPEN, closing one adds S_CL, S_CU and S_ET, S_ES or S_EV
// per result and, for a number against a non-empty previous ID, S_W0 and S_W1 to read
// the previous number digit by digit. The end of an ID adds S_ENDS, S_EEND and S_CP,
// which copies each stored character into the previous-ID memory; all memory reads are
// registered. After reset a clearing pass over max(MAX_ID_LEN, 128) addresses zeroes the
// previous-ID and token-start memories; no request is taken meanwhile. A stalled output
// holds one result each in the output and hold registers; more wait for the output to move.
module read_id_token_encoder_core #(
    parameter int MAX_ID_LEN    = 256,
    parameter int MAX_TOKENS    = 127,
    parameter int MAX_TOKEN_LEN = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rite_req_if.sink   i_req,
    rite_res_if.source o_res
);
    import rite_pkg::*;

    localparam int AW    = $clog2(MAX_ID_LEN);
    localparam int PW    = $clog2(MAX_ID_LEN + 1);
    localparam int QW    = $clog2(MAX_ID_LEN + MAX_TOKEN_LEN + 1);
    localparam int LW    = $clog2(MAX_TOKEN_LEN + 1);
    localparam int TW    = $clog2(MAX_TOKEN_LEN);
    localparam int KN    = (MAX_ID_LEN > MAX_TOKEN_LEN) ? MAX_ID_LEN : MAX_TOKEN_LEN;
    localparam int KW    = $clog2(KN + 1);
    localparam int CLR_N = (MAX_ID_LEN > 128) ? MAX_ID_LEN : 128;
    localparam int CW    = $clog2(CLR_N);

    localparam logic [4:0] S_CLEAR  = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_DEC    = 5'd2;
    localparam logic [4:0] S_OPEN   = 5'd3;
    localparam logic [4:0] S_ADD    = 5'd4;
    localparam logic [4:0] S_CL     = 5'd5;
    localparam logic [4:0] S_W0     = 5'd6;
    localparam logic [4:0] S_W1     = 5'd7;
    localparam logic [4:0] S_ET     = 5'd8;
    localparam logic [4:0] S_ES     = 5'd9;
    localparam logic [4:0] S_EV     = 5'd10;
    localparam logic [4:0] S_CU     = 5'd11;
    localparam logic [4:0] S_ENDCHK = 5'd12;
    localparam logic [4:0] S_ENDS   = 5'd13;
    localparam logic [4:0] S_CP     = 5'd14;
    localparam logic [4:0] S_EEND   = 5'd15;
    localparam logic [4:0] S_EERR   = 5'd16;
    localparam logic [4:0] S_FIN    = 5'd17;

    logic [4:0]    r_st, n_st, r_after, n_after;
    logic [CW-1:0] r_clr, n_clr;
    logic [7:0]    r_c, n_c;
    logic          r_ends, n_ends, r_empty, n_empty, r_quiet, n_quiet;
    logic [LW-1:0] r_len, n_len, r_match, n_match;
    logic [1:0]    r_cls, n_cls;
    logic [31:0]   r_num, n_num, r_pd, n_pd, r_vv, n_vv;
    logic [6:0]    r_cnt, n_cnt;
    logic [PW-1:0] r_wpos, n_wpos, r_ostart, n_ostart;
    logic          r_abort, n_abort, r_p0nz, n_p0nz;
    logic [QW-1:0] r_pa, n_pa;
    logic [KW-1:0] r_k, n_k;
    logic [3:0]    r_tval, n_tval;
    logic [2:0]    r_vs, n_vs;
    logic [1:0]    r_ecode, n_ecode;
    logic          r_ov, n_ov, r_hv, n_hv;
    t_out_req      r_out, n_out, r_hold, n_hold;

    logic          pv_we, cur_we, ts_we, tc_we;
    logic [AW-1:0] pv_waddr, cur_waddr;
    logic [7:0]    pv_wdata, pv_rdata, cur_rdata, tc_rdata;
    logic [6:0]    ts_waddr;
    logic [PW-1:0] ts_wdata, ts_rdata;
    logic [TW-1:0] tc_waddr;

    logic          prod, can_move, gate, do_drop, cont, mt, full;
    t_out_req      p;
    logic [7:0]    prev_val;
    logic [QW-1:0] sq;
    logic [6:0]    idx;
    logic [31:0]   delta;

    // Each memory is read every cycle at the next value of its pointer, so its read
    // data always belongs to the pointer's current value.
    rite_ram #(.WIDTH(8), .DEPTH(MAX_ID_LEN)) u_prev (
        .i_clk(i_clk), .i_we(pv_we), .i_waddr(pv_waddr), .i_wdata(pv_wdata),
        .i_raddr(n_pa[AW-1:0]), .o_rdata(pv_rdata)
    );
    rite_ram #(.WIDTH(8), .DEPTH(MAX_ID_LEN)) u_cur (
        .i_clk(i_clk), .i_we(cur_we), .i_waddr(cur_waddr), .i_wdata(r_c),
        .i_raddr(n_k[AW-1:0]), .o_rdata(cur_rdata)
    );
    rite_ram #(.WIDTH(PW), .DEPTH(128)) u_start (
        .i_clk(i_clk), .i_we(ts_we), .i_waddr(ts_waddr), .i_wdata(ts_wdata),
        .i_raddr(n_cnt), .o_rdata(ts_rdata)
    );
    rite_ram #(.WIDTH(8), .DEPTH(MAX_TOKEN_LEN)) u_chars (
        .i_clk(i_clk), .i_we(tc_we), .i_waddr(tc_waddr), .i_wdata(r_c),
        .i_raddr(n_k[TW-1:0]), .o_rdata(tc_rdata)
    );

    assign prev_val = (r_pa >= QW'(MAX_ID_LEN)) ? 8'd0 : pv_rdata;
    assign sq       = QW'(ts_rdata);
    assign idx      = r_cnt + 7'd1;
    assign can_move = !r_ov || o_res.ready;
    assign gate     = !r_hv || can_move;
    assign delta    = r_num - r_pd;
    assign full     = (r_match == r_len);

    always_comb begin
        case (r_cls) inside
            CLS_ALPHA:  cont = is_alpha(r_c);
            CLS_ZERO:   cont = (r_c == CH_ZERO);
            CLS_NUMBER: cont = is_digit(r_c) && (r_num < NUM_LIMIT);
            default:    cont = 1'b0;
        endcase
        if (r_len == '0) begin
            cont = 1'b0;
        end
        case (r_cls) inside
            CLS_ALPHA:  mt = full && !is_alpha(prev_val);
            CLS_ZERO:   mt = full && (prev_val != CH_ZERO);
            CLS_NUMBER: mt = full && !is_digit(prev_val);
            default:    mt = full;
        endcase
    end

    always_comb begin
        n_st = r_st; n_after = r_after; n_clr = r_clr; n_c = r_c; n_ends = r_ends;
        n_empty = r_empty; n_quiet = r_quiet; n_len = r_len; n_match = r_match;
        n_cls = r_cls; n_num = r_num; n_pd = r_pd; n_vv = r_vv; n_cnt = r_cnt;
        n_wpos = r_wpos; n_ostart = r_ostart; n_abort = r_abort; n_pa = r_pa;
        n_k = r_k; n_tval = r_tval; n_vs = r_vs; n_ecode = r_ecode;
        n_ov = r_ov && !o_res.ready; n_out = r_out; n_hv = r_hv; n_hold = r_hold;
        pv_we = 1'b0; pv_waddr = '0; pv_wdata = 8'd0;
        cur_we = 1'b0; cur_waddr = r_wpos[AW-1:0];
        ts_we = 1'b0; ts_waddr = r_cnt; ts_wdata = r_ostart;
        tc_we = 1'b0; tc_waddr = r_len[TW-1:0];
        prod = 1'b0; do_drop = 1'b0;
        p = '{token_index: idx, stream_index: ST_TYPE, value: 32'd0,
              last_result: 1'b0, error_code: ERR_NONE};

        unique case (r_st)
            S_CLEAR: begin
                pv_we    = int'(r_clr) < MAX_ID_LEN;
                pv_waddr = r_clr[AW-1:0];
                ts_we    = int'(r_clr) < 128;
                ts_waddr = r_clr[6:0];
                ts_wdata = '0;
                if (r_clr == CW'(CLR_N - 1)) begin
                    n_st = S_IDLE;
                end else begin
                    n_clr = r_clr + CW'(1);
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_c     = i_req.data.id_char;
                    n_ends  = i_req.data.last_of_id || i_req.data.empty_id;
                    n_empty = i_req.data.empty_id;
                    n_quiet = i_req.data.update_only;
                    if (r_abort) begin
                        do_drop = i_req.data.last_of_id || i_req.data.empty_id;
                    end else begin
                        n_st = S_DEC;
                    end
                end
            end
            S_DEC: begin
                if (r_empty) begin
                    n_st = S_ENDS;
                end else if (cont) begin
                    if (r_len >= LW'(MAX_TOKEN_LEN)) begin
                        n_ecode = ERR_LONG;
                        n_st    = S_EERR;
                    end else begin
                        if (r_cls == CLS_NUMBER) begin
                            n_num = (r_num << 3) + (r_num << 1) + 32'(r_c) - 32'd48;
                        end
                        n_pa = sq + QW'(r_len);
                        n_st = S_ADD;
                    end
                end else if (r_len != '0) begin
                    n_pa    = sq + QW'(r_len);
                    n_after = S_OPEN;
                    n_st    = S_CL;
                end else begin
                    n_st = S_OPEN;
                end
            end
            S_OPEN: begin
                if (is_alpha(r_c)) begin
                    n_cls = CLS_ALPHA;
                end else if (r_c == CH_ZERO) begin
                    n_cls = CLS_ZERO;
                end else if (is_digit(r_c)) begin
                    n_cls = CLS_NUMBER;
                end else begin
                    n_cls = CLS_OTHER;
                end
                n_num    = is_digit(r_c) ? (32'(r_c) - 32'd48) : 32'd0;
                n_len    = '0;
                n_match  = '0;
                n_ostart = r_wpos;
                n_pa     = sq;
                n_st     = S_ADD;
            end
            S_ADD: begin
                if (r_c == prev_val) begin
                    n_match = r_match + LW'(1);
                end
                tc_we = 1'b1;
                n_len = r_len + LW'(1);
                if (r_wpos < PW'(MAX_ID_LEN)) begin
                    cur_we = 1'b1;
                    n_wpos = r_wpos + PW'(1);
                end
                // A single other character closes as soon as it is stored.
                if (r_cls == CLS_OTHER) begin
                    n_pa    = sq + QW'(1);
                    n_after = S_ENDCHK;
                    n_st    = S_CL;
                end else begin
                    n_st = S_ENDCHK;
                end
            end
            S_CL: begin
                n_k = '0;
                if (r_quiet) begin
                    n_st = S_CU;
                end else if (mt) begin
                    n_tval = TY_MATCH;
                    n_st   = S_ET;
                end else begin
                    case (r_cls) inside
                        CLS_ALPHA, CLS_ZERO: begin
                            n_tval = TY_STRING;
                            n_st   = S_ET;
                        end
                        CLS_NUMBER: begin
                            if (r_p0nz) begin
                                n_pa = sq;
                                n_st = S_W0;
                            end else begin
                                n_tval = TY_DIGITS;
                                n_vs   = ST_DIGITS;
                                n_vv   = r_num;
                                n_st   = S_ET;
                            end
                        end
                        default: begin
                            n_tval = TY_CHAR;
                            n_vs   = ST_CHAR;
                            n_vv   = 32'(r_c);
                            n_st   = S_ET;
                        end
                    endcase
                end
            end
            S_W0: begin
                n_pd = 32'(prev_val) - 32'd48;
                n_pa = r_pa + QW'(1);
                n_st = S_W1;
            end
            S_W1: begin
                if (is_digit(prev_val)) begin
                    n_pd = (r_pd << 3) + (r_pd << 1) + 32'(prev_val) - 32'd48;
                    n_pa = r_pa + QW'(1);
                end else begin
                    if ((delta >= 32'd1) && (delta <= 32'd255)) begin
                        n_tval = TY_DDELTA;
                        n_vs   = ST_DELTA;
                        n_vv   = delta;
                    end else begin
                        n_tval = TY_DIGITS;
                        n_vs   = ST_DIGITS;
                        n_vv   = r_num;
                    end
                    n_st = S_ET;
                end
            end
            S_ET: begin
                prod    = 1'b1;
                p.value = 32'(r_tval);
                if (gate) begin
                    if (r_tval == TY_STRING) begin
                        n_st = S_ES;
                    end else if (r_tval == TY_MATCH) begin
                        n_st = S_CU;
                    end else begin
                        n_st = S_EV;
                    end
                end
            end
            S_ES: begin
                prod           = 1'b1;
                p.stream_index = ST_STR;
                if (KW'(r_len) > r_k) begin
                    p.value = 32'(tc_rdata);
                    if (gate) begin
                        n_k = r_k + KW'(1);
                    end
                end else if (gate) begin
                    n_st = S_CU;
                end
            end
            S_EV: begin
                prod           = 1'b1;
                p.stream_index = r_vs;
                p.value        = r_vv;
                if (gate) begin
                    n_st = S_CU;
                end
            end
            S_CU: begin
                ts_we   = 1'b1;
                n_cnt   = idx;
                n_len   = '0;
                n_match = '0;
                n_k     = '0;
                if (idx >= 7'(MAX_TOKENS)) begin
                    n_ecode = ERR_TOKENS;
                    n_st    = S_EERR;
                end else begin
                    n_st = r_after;
                end
            end
            S_ENDCHK: begin
                n_st = r_ends ? S_ENDS : S_FIN;
            end
            S_ENDS: begin
                n_k = '0;
                if (r_len != '0) begin
                    n_pa    = sq + QW'(r_len);
                    n_after = S_CP;
                    n_st    = S_CL;
                end else begin
                    n_st = S_CP;
                end
            end
            S_CP: begin
                if (KW'(r_wpos) > r_k) begin
                    pv_we    = 1'b1;
                    pv_waddr = r_k[AW-1:0];
                    pv_wdata = cur_rdata;
                    n_k      = r_k + KW'(1);
                end else begin
                    // Terminate the copied ID when there is room for it.
                    pv_we    = r_wpos < PW'(MAX_ID_LEN);
                    pv_waddr = r_wpos[AW-1:0];
                    n_st     = S_EEND;
                end
            end
            S_EEND: begin
                prod    = !r_quiet;
                p.value = 32'(TY_END);
                if (r_quiet || gate) begin
                    do_drop = 1'b1;
                    n_st    = S_FIN;
                end
            end
            S_EERR: begin
                prod = 1'b1;
                p    = '{token_index: 7'd0, stream_index: ST_TYPE, value: 32'd0,
                         last_result: 1'b0, error_code: r_ecode};
                if (gate) begin
                    if (r_ends) begin
                        do_drop = 1'b1;
                    end else begin
                        n_abort = 1'b1;
                    end
                    n_st = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_hv) begin
                    n_st = S_IDLE;
                end else if (can_move) begin
                    n_ov              = 1'b1;
                    n_out             = r_hold;
                    n_out.last_result = 1'b1;
                    n_hv              = 1'b0;
                    n_st              = S_IDLE;
                end
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase

        // A new result pushes the held one out, so the last one of a request can be
        // marked when the request finishes.
        if (prod && gate) begin
            if (r_hv) begin
                n_ov  = 1'b1;
                n_out = r_hold;
            end
            n_hold = p;
            n_hv   = 1'b1;
        end

        if (do_drop) begin
            n_cnt = 7'd0; n_len = '0; n_match = '0; n_cls = CLS_OTHER; n_num = 32'd0;
            n_wpos = '0; n_ostart = '0; n_abort = 1'b0;
        end

        n_p0nz = (pv_we && (pv_waddr == '0)) ? (pv_wdata != 8'd0) : r_p0nz;
    end

    assign i_req.ready = (r_st == S_IDLE);
    assign o_res.valid = r_ov;
    assign o_res.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLEAR;
            r_after <= S_FIN;
            r_clr <= '0;
            r_len <= '0;
            r_match <= '0;
            r_cls <= CLS_OTHER;
            r_num <= 32'd0;
            r_cnt <= 7'd0;
            r_wpos <= '0;
            r_ostart <= '0;
            r_abort <= 1'b0;
            r_p0nz <= 1'b0;
            r_ov <= 1'b0;
            r_hv <= 1'b0;
        end else begin
            r_st <= n_st;
            r_after <= n_after;
            r_clr <= n_clr;
            r_len <= n_len;
            r_match <= n_match;
            r_cls <= n_cls;
            r_num <= n_num;
            r_cnt <= n_cnt;
            r_wpos <= n_wpos;
            r_ostart <= n_ostart;
            r_abort <= n_abort;
            r_p0nz <= n_p0nz;
            r_ov <= n_ov;
            r_hv <= n_hv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c <= n_c;
        r_ends <= n_ends;
        r_empty <= n_empty;
        r_quiet <= n_quiet;
        r_pd <= n_pd;
        r_vv <= n_vv;
        r_pa <= n_pa;
        r_k <= n_k;
        r_tval <= n_tval;
        r_vs <= n_vs;
        r_ecode <= n_ecode;
        r_out <= n_out;
        r_hold <= n_hold;
    end
endmodule

### tb/sv/rite_token_checker.sv
`timescale 1ns / 1ps

module rite_token_checker
    import rite_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    rite_req_if  req,
    rite_res_if  res,
    output int   o_fail_cnt,
    output int   o_pending
);

    localparam int ID_LEN    = 256;
    localparam int TOK_MAX   = 127;
    localparam int TOK_CHARS = 32;

    t_out_req expected_results[$];

    logic [7:0]  prev_id[ID_LEN];
    logic [7:0]  cur_id[ID_LEN];
    int unsigned tok_start[128];
    logic [7:0]  tok_chars[TOK_CHARS];
    int unsigned tok_len;
    int unsigned n_match;
    logic [1:0]  tok_cls;
    logic [31:0] num_val;
    int unsigned tok_cnt;
    int unsigned wpos;
    int unsigned open_at;
    bit          dropping;
    int          fails = 0;

    assign o_fail_cnt = fails;
    assign o_pending  = expected_results.size();

    function automatic bit letter(input logic [7:0] c);
        return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
    endfunction

    function automatic bit decimal(input logic [7:0] c);
        return c >= 8'd48 && c <= 8'd57;
    endfunction

    function automatic logic [7:0] prev_byte(input int unsigned i);
        return (i < ID_LEN) ? prev_id[i] : 8'd0;
    endfunction

    function automatic void push_result(input int unsigned idx, input logic [2:0] st,
                                        input logic [31:0] val, input logic [1:0] err);
        t_out_req r;
        r.token_index  = idx[6:0];
        r.stream_index = st;
        r.value        = val;
        r.last_result  = 1'b0;
        r.error_code   = err;
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic void clear_id();
        tok_cnt  = 0;
        tok_len  = 0;
        n_match  = 0;
        tok_cls  = CLS_OTHER;
        num_val  = '0;
        wpos     = 0;
        open_at  = 0;
        dropping = 0;
    endfunction

    function automatic void append_char(input logic [7:0] c);
        int unsigned s;
        s = tok_start[tok_cnt % 128];
        if (c == prev_byte(s + tok_len))
            n_match++;
        if (tok_len < TOK_CHARS)
            tok_chars[tok_len] = c;
        tok_len++;
        if (wpos < ID_LEN) begin
            cur_id[wpos] = c;
            wpos++;
        end
    endfunction

    function automatic void start_token(input logic [7:0] c);
        if (letter(c))
            tok_cls = CLS_ALPHA;
        else if (c == CH_ZERO)
            tok_cls = CLS_ZERO;
        else if (decimal(c))
            tok_cls = CLS_NUMBER;
        else
            tok_cls = CLS_OTHER;
        num_val = decimal(c) ? 32'(c - 8'd48) : 32'd0;
        tok_len = 0;
        n_match = 0;
        open_at = wpos;
        append_char(c);
    endfunction

    // Returns 1 when this close hits the token count limit.
    function automatic bit finish_token(input bit quiet);
        int unsigned s;
        int unsigned idx;
        int unsigned t;
        logic [7:0]  nxt;
        logic [31:0] pd;
        logic [31:0] delta;
        bit          full;
        bit          same;
        bit          use_delta;
        s    = tok_start[tok_cnt % 128];
        nxt  = prev_byte(s + tok_len);
        full = (n_match == tok_len);
        idx  = tok_cnt + 1;
        if (!quiet) begin
            case (tok_cls)
                CLS_ALPHA:  same = full && !letter(nxt);
                CLS_ZERO:   same = full && nxt != CH_ZERO;
                CLS_NUMBER: same = full && !decimal(nxt);
                default:    same = full;
            endcase
            if (same) begin
                push_result(idx, ST_TYPE, 32'(TY_MATCH), ERR_NONE);
            end else if (tok_cls == CLS_ALPHA || tok_cls == CLS_ZERO) begin
                push_result(idx, ST_TYPE, 32'(TY_STRING), ERR_NONE);
                for (int k = 0; k < tok_len && k < TOK_CHARS; k++)
                    push_result(idx, ST_STR, 32'(tok_chars[k]), ERR_NONE);
                push_result(idx, ST_STR, 32'd0, ERR_NONE);
            end else if (tok_cls == CLS_NUMBER) begin
                use_delta = 0;
                delta     = '0;
                if (prev_byte(0) != 8'd0) begin
                    pd = 32'(prev_byte(s)) - 32'd48;
                    t  = 1;
                    while (decimal(prev_byte(s + t))) begin
                        pd = pd * 32'd10 + (32'(prev_byte(s + t)) - 32'd48);
                        t++;
                    end
                    delta     = num_val - pd;
                    use_delta = delta >= 32'd1 && delta <= 32'd255;
                end
                if (use_delta) begin
                    push_result(idx, ST_TYPE, 32'(TY_DDELTA), ERR_NONE);
                    push_result(idx, ST_DELTA, delta, ERR_NONE);
                end else begin
                    push_result(idx, ST_TYPE, 32'(TY_DIGITS), ERR_NONE);
                    push_result(idx, ST_DIGITS, num_val, ERR_NONE);
                end
            end else begin
                push_result(idx, ST_TYPE, 32'(TY_CHAR), ERR_NONE);
                push_result(idx, ST_CHAR, 32'(tok_chars[0]), ERR_NONE);
            end
        end
        tok_start[tok_cnt % 128] = open_at;
        tok_cnt++;
        tok_len = 0;
        n_match = 0;
        if (tok_cnt >= TOK_MAX) begin
            push_result(0, ST_TYPE, 32'd0, ERR_TOKENS);
            return 1;
        end
        return 0;
    endfunction

    function automatic void encode_request(input t_in_req d);
        int  first;
        bit  ends;
        bit  err;
        bit  grow;
        first = expected_results.size();
        ends  = d.last_of_id || d.empty_id;
        err   = 0;
        if (dropping) begin
            if (ends)
                clear_id();
            return;
        end
        if (!d.empty_id) begin
            grow = 0;
            if (tok_len != 0) begin
                case (tok_cls)
                    CLS_ALPHA:  grow = letter(d.id_char);
                    CLS_ZERO:   grow = d.id_char == CH_ZERO;
                    CLS_NUMBER: grow = decimal(d.id_char) && num_val < NUM_LIMIT;
                    default:    grow = 0;
                endcase
            end
            if (grow) begin
                if (tok_len >= TOK_CHARS) begin
                    push_result(0, ST_TYPE, 32'd0, ERR_LONG);
                    err = 1;
                end else begin
                    if (tok_cls == CLS_NUMBER)
                        num_val = num_val * 32'd10 + 32'(d.id_char - 8'd48);
                    append_char(d.id_char);
                end
            end else begin
                if (tok_len != 0)
                    err = finish_token(d.update_only);
                if (!err) begin
                    start_token(d.id_char);
                    if (tok_cls == CLS_OTHER)
                        err = finish_token(d.update_only);
                end
            end
        end
        if (err) begin
            if (ends)
                clear_id();
            else
                dropping = 1;
        end else if (ends) begin
            if (tok_len != 0)
                err = finish_token(d.update_only);
            if (!err) begin
                for (int k = 0; k < wpos && k < ID_LEN; k++)
                    prev_id[k] = cur_id[k];
                if (wpos < ID_LEN)
                    prev_id[wpos] = 8'd0;
                if (!d.update_only)
                    push_result(tok_cnt + 1, ST_TYPE, 32'(TY_END), ERR_NONE);
            end
            clear_id();
        end
        if (expected_results.size() > first)
            expected_results[expected_results.size() - 1].last_result = 1'b1;
    endfunction

    initial begin
        foreach (prev_id[i]) prev_id[i] = '0;
        foreach (cur_id[i]) cur_id[i] = '0;
        foreach (tok_start[i]) tok_start[i] = 0;
        foreach (tok_chars[i]) tok_chars[i] = '0;
        clear_id();
    end

    always @(posedge i_clk) begin
        t_out_req want;
        if (i_rst_n) begin
            if (res.valid && res.ready) begin
                if (expected_results.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result %p", res.data);
                end else begin
                    want = expected_results.pop_front();
                    if (res.data !== want) begin
                        fails++;
                        if (fails <= 10)
                            $display("result mismatch: expected %p, got %p", want, res.data);
                    end
                end
            end
            if (req.valid && req.ready)
                encode_request(req.data);
        end
    end

endmodule

### tb/sv/tb_read_id_token_encoder_core.sv
`timescale 1ns / 1ps

module tb_read_id_token_encoder_core;
    import rite_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_cnt;
    int   pending;
    bit   calm = 0;
    bit   want_hold = 0;
    int   words_done;

    rite_req_if req ();
    rite_res_if res ();

    read_id_token_encoder_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_res   (res)
    );

    rite_token_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .req        (req),
        .res        (res),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Output side: random stall bursts, one long hold-off on request.
    initial begin
        bit held;
        held = 0;
        res.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (want_hold && !held) begin
                res.ready <= 1'b0;
                repeat (600) @(posedge i_clk);
                held = 1;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                res.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end
            res.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
        end
    end

    task automatic send_request(input logic [7:0] c, input bit last, input bit empty,
                                input bit quiet);
        if (!calm && !want_hold && $urandom_range(0, 5) == 0) begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        req.valid            <= 1'b1;
        req.data.id_char     <= c;
        req.data.last_of_id  <= last;
        req.data.empty_id    <= empty;
        req.data.update_only <= quiet;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
    endtask

    task automatic send_id(input string s, input bit quiet);
        if (s.len() == 0) begin
            send_request(8'($urandom_range(0, 255)), $urandom_range(0, 1), 1'b1, quiet);
        end else begin
            for (int i = 0; i < s.len(); i++)
                send_request(s[i], i == s.len() - 1, 1'b0, quiet);
        end
    endtask

    int unsigned base_num[8];
    string       base_word[8];

    function automatic string make_id();
        string s;
        int    n;
        n = $urandom_range(1, 7);
        s = "";
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 5))
                0: begin
                    if ($urandom_range(0, 3) == 0)
                        base_word[k] = ($urandom_range(0, 1)) ? "SRR" : "Lane";
                    s = {s, base_word[k]};
                end
                1, 2: begin
                    if ($urandom_range(0, 7) == 0)
                        base_num[k] = $urandom_range(1, 99999);
                    else
                        base_num[k] += $urandom_range(0, 300);
                    s = {s, $sformatf("%0d", base_num[k])};
                end
                3: s = {s, ($urandom_range(0, 1)) ? "00" : "0"};
                default: s = {s, ($urandom_range(0, 2) == 0) ? "_" : ":"};
            endcase
            if ($urandom_range(0, 1)) s = {s, ":"};
        end
        return s;
    endfunction

    function automatic string noise_id();
        string s;
        s = "";
        for (int k = $urandom_range(1, 10); k > 0; k--)
            s = {s, string'(8'($urandom_range(1, 255)))};
        return s;
    endfunction

    initial begin
        string s;
        req.valid = 1'b0;
        req.data  = '0;
        foreach (base_num[i]) base_num[i] = $urandom_range(1, 5000);
        foreach (base_word[i]) base_word[i] = "HWI";
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: matching, deltas, empty ID, number cap, zero runs, odd bytes.
        send_id("AB12:0007x", 0);
        send_id("AB13:0007y", 0);
        send_id("", 0);
        send_id("Q9999999999", 0);
        send_request(8'd0, 1'b0, 1'b0, 1'b0);
        send_request(8'd255, 1'b0, 1'b0, 1'b0);
        send_request(8'd128, 1'b1, 1'b0, 1'b1);
        send_id("AB200:00", 1);
        send_id("AB201:00", 0);
        // Token too long, then the rest of that ID is dropped.
        s = "";
        repeat (33) s = {s, "a"};
        send_id({s, "b:1"}, 0);
        // Too many tokens.
        s = "";
        repeat (130) s = {s, ":"};
        send_id(s, 0);
        send_id("AB14:0007x", 0);

        want_hold = 1;
        for (int i = 0; i < 40; i++)
            send_request(8'(8'd65 + i % 20), i % 10 == 9, 1'b0, 1'b0);
        want_hold = 0;

        words_done = 0;
        while (words_done < 170) begin
            if (words_done > 130) calm = 1;
            case ($urandom_range(0, 9))
                0:       s = noise_id();
                1:       s = "";
                default: s = make_id();
            endcase
            send_id(s, $urandom_range(0, 9) == 0);
            words_done += (s.len() == 0) ? 1 : s.len();
        end
        req.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #4ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

### filelist.f
src/rite_pkg.sv
src/rite_if.sv
src/rite_ram.sv
src/read_id_token_encoder_core.sv
tb/sv/rite_token_checker.sv
tb/sv/tb_read_id_token_encoder_core.sv
